>>> rtl/core/bpq_pkg.sv
// Shared types, codes and the entry ranking function of the bounded priority queue.
`timescale 1ns / 1ps

package bpq_pkg;

    localparam int CAPACITY_DEF = 8;
    localparam int OCC_W        = 4;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [31:0] prio;
        logic signed [31:0] value;
    } entry_t;

    // Operation broadcast to every cell, already qualified by accept and status.
    typedef struct packed {
        logic   push;
        logic   pop;
        entry_t entry;
    } op_t;

    // What a cell shows to its neighbors.
    typedef struct packed {
        logic   valid;
        entry_t entry;
        logic   displaced;
    } cell_link_t;

    // True when entry a ranks strictly above entry b.
    function automatic logic ranks_above(entry_t a, entry_t b);
        logic result;
        if (a.prio != b.prio)
        begin
            result = (a.prio > b.prio);
        end
        else
        begin
            result = (a.value > b.value);
        end
        return result;
    endfunction

endpackage

>>> rtl/core/bpq_cell.sv
// One cell of the sorted shift-register queue: holds one entry, shifts right on push, left on pop.
`timescale 1ns / 1ps

module bpq_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  bpq_pkg::op_t       op,
    input  bpq_pkg::cell_link_t left,
    input  bpq_pkg::cell_link_t right,
    output bpq_pkg::cell_link_t self
);

    logic            valid_reg;
    logic            valid_next;
    bpq_pkg::entry_t entry_reg;
    bpq_pkg::entry_t entry_next;
    logic            displaced;

    assign displaced = op.push && (!valid_reg || bpq_pkg::ranks_above(op.entry, entry_reg));

    always_comb
    begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        priority if (op.push)
        begin
            priority if (left.displaced)
            begin
                valid_next = left.valid;
                entry_next = left.entry;
            end
            else if (displaced)
            begin
                valid_next = 1'b1;
                entry_next = op.entry;
            end
            else
            begin
                valid_next = valid_reg;
                entry_next = entry_reg;
            end
        end
        else if (op.pop)
        begin
            valid_next = right.valid;
            entry_next = right.entry;
        end
        else
        begin
            valid_next = valid_reg;
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign self.valid     = valid_reg;
    assign self.entry     = entry_reg;
    assign self.displaced = displaced;

endmodule

>>> rtl/core/bounded_priority_queue.sv
// Top level of the bounded max priority queue built as a chain of sorted cells.
`timescale 1ns / 1ps

// Bounded max priority queue of CAPACITY entries kept sorted in a row of cells,
// best entry in cell 0. A push is broadcast to all cells at once; each cell
// compares it with its own entry and keeps, takes the new entry or takes its
// left neighbor's entry. A pop shifts every cell one place toward the head.
// One item is accepted per cycle while out_ready is high or no result waits,
// and its result appears in the output register the cycle after; the next item
// is taken as soon as that result is taken. Each cell holds one 64-bit compare,
// which sets the clock period. Occupancy is the count masked to 4 bits.
module bounded_priority_queue #(
    parameter int CAPACITY = bpq_pkg::CAPACITY_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               command,
    input  logic signed [31:0] value,
    input  logic signed [31:0] priority_req,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic signed [31:0] popped_value,
    output logic signed [31:0] popped_priority,
    output logic [3:0]         occupancy,
    output logic               head_valid,
    output logic signed [31:0] head_value,
    output logic signed [31:0] head_priority
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int OCC_X = (CNT_W > bpq_pkg::OCC_W) ? CNT_W : bpq_pkg::OCC_W;

    bpq_pkg::cell_link_t cell_q [CAPACITY];
    bpq_pkg::op_t        op;
    logic                accept;
    logic                full;
    logic                empty;
    logic                push_ok;
    logic                pop_ok;

    logic                out_valid_reg;
    logic                out_valid_next;
    bpq_pkg::status_t    status_reg;
    bpq_pkg::status_t    status_next;
    bpq_pkg::entry_t     popped_reg;
    bpq_pkg::entry_t     popped_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [OCC_X-1:0]    occ_wide;

    assign accept  = in_valid && in_ready;
    assign in_ready = !out_valid_reg || out_ready;
    assign full    = cell_q[CAPACITY-1].valid;
    assign empty   = !cell_q[0].valid;
    assign push_ok = accept && (command == bpq_pkg::CMD_PUSH) && !full;
    assign pop_ok  = accept && (command == bpq_pkg::CMD_POP) && !empty;

    assign op.push        = push_ok;
    assign op.pop         = pop_ok;
    assign op.entry.value = value;
    assign op.entry.prio  = priority_req;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            bpq_pkg::cell_link_t left_link;
            bpq_pkg::cell_link_t right_link;
            if (gi == 0)
            begin : g_first
                assign left_link = '0;
            end
            else
            begin : g_mid
                assign left_link = cell_q[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_link = '0;
            end
            else
            begin : g_inner
                assign right_link = cell_q[gi+1];
            end
            bpq_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .op    (op),
                .left  (left_link),
                .right (right_link),
                .self  (cell_q[gi])
            );
        end
    endgenerate

    always_comb
    begin
        status_next    = status_reg;
        popped_next    = popped_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept)
        begin
            out_valid_next = 1'b1;
            popped_next    = '0;
            priority if (command == bpq_pkg::CMD_PUSH && full)
            begin
                status_next = bpq_pkg::ST_FULL;
            end
            else if (command == bpq_pkg::CMD_POP && empty)
            begin
                status_next = bpq_pkg::ST_EMPTY;
            end
            else
            begin
                status_next = bpq_pkg::ST_DONE;
            end
            if (pop_ok)
            begin
                popped_next = cell_q[0].entry;
                count_next  = count_reg - CNT_W'(1);
            end
            if (push_ok)
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        popped_reg <= popped_next;
    end

    assign occ_wide        = OCC_X'(count_reg);
    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign popped_value    = popped_reg.value;
    assign popped_priority = popped_reg.prio;
    assign occupancy       = occ_wide[bpq_pkg::OCC_W-1:0];
    assign head_valid      = cell_q[0].valid;
    assign head_value      = cell_q[0].valid ? cell_q[0].entry.value : '0;
    assign head_priority   = cell_q[0].valid ? cell_q[0].entry.prio : '0;

endmodule

>>> rtl/core/bpq_checker.sv
// Port-level assertions for the bounded priority queue, bound to the top level.
`timescale 1ns / 1ps

module bpq_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               command,
    input logic               out_valid,
    input logic               out_ready,
    input logic [1:0]         status,
    input logic signed [31:0] popped_priority,
    input logic [3:0]         occupancy,
    input logic               head_valid,
    input logic signed [31:0] head_priority
);

    logic last_pop_reg;
    logic last_pop_next;

    assign last_pop_next = (in_valid && in_ready) ? (command == bpq_pkg::CMD_POP) : last_pop_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_pop_reg <= 1'b0;
        end
        else
        begin
            last_pop_reg <= last_pop_next;
        end
    end

    a_full_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == bpq_pkg::ST_FULL |-> head_valid)
        else $error("full status with empty head");

    a_empty_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == bpq_pkg::ST_EMPTY |-> !head_valid && occupancy == 4'd0)
        else $error("empty status with entries held");

    a_no_head_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !head_valid |-> occupancy == 4'd0)
        else $error("no head but nonzero occupancy");

    a_pop_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_pop_reg && status == bpq_pkg::ST_DONE && head_valid
        |-> popped_priority >= head_priority)
        else $error("popped entry ranks below remaining head");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(popped_priority))
        else $error("result changed while stalled");

endmodule

bind bounded_priority_queue bpq_checker u_bpq_checker (.*);
